// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the retarget top module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// ante |-> cons, sampled on the rising edge, off while in reset
`define PDR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdr assertion failed");
// ante |=> cons
`define PDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdr assertion failed");
`else
`define PDR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PDR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/pdr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdr_pkg
// Types, constants and compact-word helpers for the difficulty retarget.
// ----------------------------------------------------------------------------
package pdr_pkg;

    localparam int NUM_BYTES = 32;
    localparam int TGT_W     = 8 * NUM_BYTES;
    localparam int BITS_W    = 32;
    localparam int TIME_W    = 32;
    localparam int SPAN_W    = 32;
    localparam int SPACING_W = 16;
    localparam int INTVL_W   = 14;
    localparam int EXPECT_W  = SPACING_W + INTVL_W;
    localparam int CFG_ADDR_W = 2;

    localparam logic [SPACING_W-1:0] RST_SPACING = 16'd600;
    localparam logic [INTVL_W-1:0]   RST_INTVL   = 14'd2016;
    localparam logic [BITS_W-1:0]    RST_LIMIT   = 32'h1d00ffff;
    localparam logic [EXPECT_W-1:0]  RST_EXPECT  = 30'(600 * 2016);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SPACING  = 2'd0,
        REG_INTERVAL = 2'd1,
        REG_LIMIT    = 2'd2,
        REG_NONE     = 2'd3
    } pdr_reg_t;

    // sideband that travels with each item down the chain
    typedef struct packed {
        logic              valid;
        logic              bypass;
        logic [BITS_W-1:0] bypass_bits;
    } pdr_side_t;

    // compact word -> 256-bit target, sign bit ignored
    function automatic logic [TGT_W-1:0] decode_bits(input logic [BITS_W-1:0] bits);
        logic [7:0]       expo;
        logic [TGT_W-1:0] m;
        logic [TGT_W-1:0] r;
        expo = bits[31:24];
        m    = {{(TGT_W-23){1'b0}}, bits[22:0]};
        if (expo < 8'd3)
            r = m >> {(2'd3 - expo[1:0]), 3'b000};
        else if (expo >= 8'd35)
            r = '0;
        else
            r = m << {(expo[5:0] - 6'd3), 3'b000};
        return r;
    endfunction

    // 256-bit target -> compact word
    function automatic logic [BITS_W-1:0] encode_bits(input logic [TGT_W-1:0] t);
        logic [4:0]  lead;
        logic [4:0]  sel;
        logic [23:0] mant;
        logic [5:0]  size;
        logic [BITS_W-1:0] r;
        lead = '0;
        for (int j = 0; j < NUM_BYTES; j++)
        begin
            if (t[8*j +: 8] != 8'd0)
                lead = 5'(j);
        end
        sel  = (lead >= 5'd2) ? (lead - 5'd2) : 5'd0;
        mant = t[8*sel +: 24];
        size = {1'b0, lead} + 6'd1;
        if (mant[23])
        begin
            mant = mant >> 8;
            size = size + 6'd1;
        end
        if (t == '0)
            r = '0;
        else
            r = {2'b00, size, 1'b0, mant[22:0]};
        return r;
    endfunction

endpackage

// ===== src/pdr_mul_cell.sv =====
// ----------------------------------------------------------------------------
// pdr_mul_cell
// One byte of the target times the span, carry to the next cell.
// ----------------------------------------------------------------------------
module pdr_mul_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pdr_pkg::pdr_side_t            side_in,
    input  logic [pdr_pkg::TGT_W-1:0]     tgt_in,
    input  logic [pdr_pkg::SPAN_W-1:0]    span_in,
    input  logic [pdr_pkg::SPAN_W-1:0]    carry_in,
    output pdr_pkg::pdr_side_t            side_out,
    output logic [pdr_pkg::TGT_W-1:0]     tgt_out,
    output logic [pdr_pkg::SPAN_W-1:0]    span_out,
    output logic [pdr_pkg::SPAN_W-1:0]    carry_out
);

    pdr_pkg::pdr_side_t                side_reg;
    logic [pdr_pkg::TGT_W-1:0]         tgt_reg;
    logic [pdr_pkg::TGT_W-1:0]         tgt_next;
    logic [pdr_pkg::SPAN_W-1:0]        span_reg;
    logic [pdr_pkg::SPAN_W-1:0]        carry_reg;
    logic [pdr_pkg::SPAN_W-1:0]        carry_next;
    logic [pdr_pkg::SPAN_W+7:0]        acc;

    // low byte is processed, then rotated to the top
    always_comb
    begin
        acc = {{pdr_pkg::SPAN_W{1'b0}}, tgt_in[7:0]} * {8'd0, span_in}
            + {8'd0, carry_in};
        tgt_next   = {acc[7:0], tgt_in[pdr_pkg::TGT_W-1:8]};
        carry_next = acc[pdr_pkg::SPAN_W+7:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else
            side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        tgt_reg   <= tgt_next;
        span_reg  <= span_in;
        carry_reg <= carry_next;
    end

    assign side_out  = side_reg;
    assign tgt_out   = tgt_reg;
    assign span_out  = span_reg;
    assign carry_out = carry_reg;

endmodule

// ===== src/pdr_div_cell.sv =====
// ----------------------------------------------------------------------------
// pdr_div_cell
// One quotient byte of the target over the expected span.
// ----------------------------------------------------------------------------
module pdr_div_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pdr_pkg::EXPECT_W-1:0]  divisor,
    input  pdr_pkg::pdr_side_t            side_in,
    input  logic [pdr_pkg::TGT_W-1:0]     tgt_in,
    input  logic [pdr_pkg::EXPECT_W-1:0]  rem_in,
    output pdr_pkg::pdr_side_t            side_out,
    output logic [pdr_pkg::TGT_W-1:0]     tgt_out,
    output logic [pdr_pkg::EXPECT_W-1:0]  rem_out
);

    pdr_pkg::pdr_side_t              side_reg;
    logic [pdr_pkg::TGT_W-1:0]       tgt_reg;
    logic [pdr_pkg::TGT_W-1:0]       tgt_next;
    logic [pdr_pkg::EXPECT_W-1:0]    rem_reg;
    logic [pdr_pkg::EXPECT_W-1:0]    rem_next;
    logic [pdr_pkg::EXPECT_W:0]      r;
    logic [7:0]                      q;
    logic [7:0]                      byte_in;

    // restoring division, 8 steps; top byte in, quotient rotated into the bottom
    always_comb
    begin
        byte_in = tgt_in[pdr_pkg::TGT_W-1 -: 8];
        r = {1'b0, rem_in};
        q = '0;
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[pdr_pkg::EXPECT_W-1:0], byte_in[i]};
            if (divisor != '0 && r >= {1'b0, divisor})
            begin
                r    = r - {1'b0, divisor};
                q[i] = 1'b1;
            end
        end
        rem_next = r[pdr_pkg::EXPECT_W-1:0];
        tgt_next = {tgt_in[pdr_pkg::TGT_W-9:0], q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else
            side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        tgt_reg <= tgt_next;
        rem_reg <= rem_next;
    end

    assign side_out = side_reg;
    assign tgt_out  = tgt_reg;
    assign rem_out  = rem_reg;

endmodule

// ===== src/pow_difficulty_retarget_top.sv =====
// ----------------------------------------------------------------------------
// pow_difficulty_retarget_top
// A start transfer passes the front, multiply, divide, clamp and result registers before the done strobe.
// Throughput: one transfer per cycle; the row of 32 multiply cells and
//   32 divide cells (one target byte each) is fully pipelined.
// busy stays low; done is a one-cycle strobe the receiver cannot stall.
// Reset clears configuration to 600 / 2016 / 0x1d00ffff and all valid flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pow_difficulty_retarget_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [pdr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pdr_pkg::BITS_W-1:0]       cfg_wdata,
    // command side
    input  logic                             start,
    output logic                             busy,
    input  logic [pdr_pkg::BITS_W-1:0]       prev_bits,
    input  logic [pdr_pkg::TIME_W-1:0]       first_time,
    input  logic [pdr_pkg::TIME_W-1:0]       last_time,
    // result side
    output logic                             done,
    output logic [pdr_pkg::BITS_W-1:0]       next_bits
);

    localparam int NB       = pdr_pkg::NUM_BYTES;
    localparam int PIPE_LAT = 2 * pdr_pkg::NUM_BYTES + 3;

    // ---------------- configuration registers ----------------
    logic [pdr_pkg::SPACING_W-1:0] spacing_reg;
    logic [pdr_pkg::SPACING_W-1:0] spacing_next;
    logic [pdr_pkg::INTVL_W-1:0]   interval_reg;
    logic [pdr_pkg::INTVL_W-1:0]   interval_next;
    logic [pdr_pkg::BITS_W-1:0]    limit_reg;
    logic [pdr_pkg::BITS_W-1:0]    limit_next;
    logic [pdr_pkg::EXPECT_W-1:0]  expect_reg;
    pdr_pkg::pdr_reg_t             cfg_sel;

    assign cfg_sel = pdr_pkg::pdr_reg_t'(cfg_addr);

    always_comb
    begin
        spacing_next  = spacing_reg;
        interval_next = interval_reg;
        limit_next    = limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_sel)
                pdr_pkg::REG_SPACING:  spacing_next  = cfg_wdata[pdr_pkg::SPACING_W-1:0];
                pdr_pkg::REG_INTERVAL: interval_next = cfg_wdata[pdr_pkg::INTVL_W-1:0];
                pdr_pkg::REG_LIMIT:    limit_next    = cfg_wdata;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg  <= pdr_pkg::RST_SPACING;
            interval_reg <= pdr_pkg::RST_INTVL;
            limit_reg    <= pdr_pkg::RST_LIMIT;
        end
        else
        begin
            spacing_reg  <= spacing_next;
            interval_reg <= interval_next;
            limit_reg    <= limit_next;
        end
    end

    // expected span, registered from the next register values so it is
    // current on the first cycle after a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expect_reg <= pdr_pkg::RST_EXPECT;
        else
            expect_reg <= {{pdr_pkg::INTVL_W{1'b0}}, spacing_next}
                        * {{pdr_pkg::SPACING_W{1'b0}}, interval_next};
    end

    // pipeline never stalls
    assign busy = 1'b0;

    // ---------------- front stage: span clamp, bypass, decode ----------------
    logic                          accept;
    logic                          disabled;
    logic                          pinned;
    logic [pdr_pkg::SPAN_W-1:0]    span_raw;
    logic [pdr_pkg::SPAN_W-1:0]    span_lo;
    logic [pdr_pkg::SPAN_W-1:0]    span_hi;
    logic [pdr_pkg::SPAN_W-1:0]    span_exp;
    logic [pdr_pkg::SPAN_W-1:0]    span_next;
    pdr_pkg::pdr_side_t            front_side_next;
    pdr_pkg::pdr_side_t            front_side_reg;
    logic [pdr_pkg::TGT_W-1:0]     front_tgt_reg;
    logic [pdr_pkg::SPAN_W-1:0]    front_span_reg;

    assign accept = start && !busy;

    always_comb
    begin
        disabled = (spacing_reg == '0) || (interval_reg == '0);
        span_exp = {2'b00, expect_reg};
        span_lo  = {4'b0000, expect_reg[pdr_pkg::EXPECT_W-1:2]};
        span_hi  = {expect_reg, 2'b00};
        span_raw = (last_time > first_time) ? (last_time - first_time) : span_exp;
        if (span_raw < span_lo)
            span_next = span_lo;
        else if (span_raw > span_hi)
            span_next = span_hi;
        else
            span_next = span_raw;
        pinned = (prev_bits == limit_reg) && (span_next >= span_exp);
        front_side_next.valid       = accept;
        front_side_next.bypass      = disabled || pinned;
        front_side_next.bypass_bits = disabled ? prev_bits : limit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_side_reg <= '0;
        else
            front_side_reg <= front_side_next;
    end

    always_ff @(posedge clk)
    begin
        front_tgt_reg  <= pdr_pkg::decode_bits(prev_bits);
        front_span_reg <= span_next;
    end

    // ---------------- multiply row: low byte first, carry ripples up ----------------
    pdr_pkg::pdr_side_t            mul_side  [NB+1];
    logic [pdr_pkg::TGT_W-1:0]     mul_tgt   [NB+1];
    logic [pdr_pkg::SPAN_W-1:0]    mul_span  [NB+1];
    logic [pdr_pkg::SPAN_W-1:0]    mul_carry [NB+1];

    assign mul_side[0]  = front_side_reg;
    assign mul_tgt[0]   = front_tgt_reg;
    assign mul_span[0]  = front_span_reg;
    assign mul_carry[0] = '0;

    for (genvar g = 0; g < NB; g++)
    begin : g_mul
        pdr_mul_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .side_in   (mul_side[g]),
            .tgt_in    (mul_tgt[g]),
            .span_in   (mul_span[g]),
            .carry_in  (mul_carry[g]),
            .side_out  (mul_side[g+1]),
            .tgt_out   (mul_tgt[g+1]),
            .span_out  (mul_span[g+1]),
            .carry_out (mul_carry[g+1])
        );
    end

    // ---------------- divide row: high byte first, remainder ripples down ----------------
    // final carry and span fall off: the product wraps at 256 bits
    pdr_pkg::pdr_side_t            div_side [NB+1];
    logic [pdr_pkg::TGT_W-1:0]     div_tgt  [NB+1];
    logic [pdr_pkg::EXPECT_W-1:0]  div_rem  [NB+1];
    logic                          tail_unused;

    assign div_side[0] = mul_side[NB];
    assign div_tgt[0]  = mul_tgt[NB];
    assign div_rem[0]  = '0;
    assign tail_unused = ^{mul_carry[NB], mul_span[NB], div_rem[NB]};

    for (genvar g = 0; g < NB; g++)
    begin : g_div
        pdr_div_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .divisor  (expect_reg),
            .side_in  (div_side[g]),
            .tgt_in   (div_tgt[g]),
            .rem_in   (div_rem[g]),
            .side_out (div_side[g+1]),
            .tgt_out  (div_tgt[g+1]),
            .rem_out  (div_rem[g+1])
        );
    end

    // ---------------- clamp to the limit target ----------------
    pdr_pkg::pdr_side_t            clamp_side_reg;
    logic [pdr_pkg::TGT_W-1:0]     clamp_tgt_reg;
    logic [pdr_pkg::TGT_W-1:0]     clamp_tgt_next;
    logic [pdr_pkg::TGT_W-1:0]     lim_tgt;

    always_comb
    begin
        lim_tgt = pdr_pkg::decode_bits(limit_reg);
        clamp_tgt_next = (div_tgt[NB] > lim_tgt) ? lim_tgt : div_tgt[NB];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clamp_side_reg <= '0;
        else
            clamp_side_reg <= div_side[NB];
    end

    always_ff @(posedge clk)
    begin
        clamp_tgt_reg <= clamp_tgt_next;
    end

    // ---------------- encode and result register ----------------
    logic                       done_reg;
    logic [pdr_pkg::BITS_W-1:0] next_bits_reg;
    logic [pdr_pkg::BITS_W-1:0] next_bits_next;

    always_comb
    begin
        if (clamp_side_reg.bypass)
            next_bits_next = clamp_side_reg.bypass_bits;
        else
            next_bits_next = pdr_pkg::encode_bits(clamp_tgt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= clamp_side_reg.valid || (tail_unused && 1'b0);
    end

    always_ff @(posedge clk)
    begin
        next_bits_reg <= next_bits_next;
    end

    assign done      = done_reg;
    assign next_bits = next_bits_reg;

    // ---------------- assertions ----------------
    // every strobe traces back to an accepted transfer
    `PDR_ASSERT_IMPL(a_done_from_start, clk, rst_n, done, $past(accept, PIPE_LAT))
    // every accepted transfer yields its strobe
    `PDR_ASSERT_IMPL(a_start_gives_done, clk, rst_n, accept, ##PIPE_LAT done)
    // an item leaving the divide row is strobed after the clamp and result registers
    `PDR_ASSERT_NEXT(a_clamp_to_done, clk, rst_n, div_side[NB].valid, ##1 done)

endmodule
